// ===== hw/rtl/utf8dc_pkg.sv =====
// Shared types, constants and classification functions for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8dc_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned CntWidth = 3;

  typedef logic [CpWidth-1:0]  cp_t;
  typedef logic [CntWidth-1:0] cnt_t;

  typedef struct packed {
    cp_t  code_point;
    cnt_t seq_bytes;
    logic bad_lead;
  } dec_item_t;

  localparam logic [7:0] LeadMultiLo = 8'hC0;
  localparam logic [7:0] LeadBadLo   = 8'hFE;

  localparam cp_t GreekLowerLo    = 31'h3B1;
  localparam cp_t GreekLowerHi    = 31'h3C9;
  localparam cp_t CyrLowerLo      = 31'h430;
  localparam cp_t CyrLowerHi      = 31'h44F;
  localparam cp_t CyrLowerExtLo   = 31'h450;
  localparam cp_t CyrLowerExtHi   = 31'h45F;
  localparam cp_t CyrPairLo       = 31'h48B;
  localparam cp_t CyrPairHi       = 31'h52F;
  localparam cp_t OghamSpace      = 31'h1680;
  localparam cp_t MongolVowelSep  = 31'h180E;
  localparam cp_t NarrowNbsp      = 31'h202F;
  localparam cp_t ZeroWidthNbsp   = 31'hFEFF;

  localparam cp_t CaseOffset      = 31'h20;
  localparam cp_t CyrExtOffset    = 31'h50;

  function automatic logic in_range(cp_t v, cp_t lo, cp_t hi);
    in_range = (v >= lo) && (v <= hi);
  endfunction

  function automatic cnt_t lead_len(logic [7:0] b);
    if (b < 8'hE0) begin
      lead_len = 3'd1;
    end else if (b < 8'hF0) begin
      lead_len = 3'd2;
    end else if (b < 8'hF8) begin
      lead_len = 3'd3;
    end else if (b < 8'hFC) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd5;
    end
  endfunction

  function automatic logic odd_pair_range(cp_t c);
    odd_pair_range = c[0] && (in_range(c, 31'h101, 31'h17E) ||
                              in_range(c, 31'h461, 31'h481) ||
                              in_range(c, CyrPairLo, CyrPairHi));
  endfunction

  function automatic logic even_pair_range(cp_t c);
    even_pair_range = !c[0] && (in_range(c, 31'h100, 31'h17D) ||
                                in_range(c, 31'h460, 31'h480) ||
                                in_range(c, CyrPairLo - 31'd1, CyrPairHi - 31'd1));
  endfunction

  function automatic cp_t map_upper(cp_t c);
    if (in_range(c, 31'h61, 31'h7A) || in_range(c, 31'hE0, 31'hFE) ||
        in_range(c, GreekLowerLo, GreekLowerHi) || in_range(c, CyrLowerLo, CyrLowerHi)) begin
      map_upper = c - CaseOffset;
    end else if (in_range(c, CyrLowerExtLo, CyrLowerExtHi)) begin
      map_upper = c - CyrExtOffset;
    end else if (odd_pair_range(c)) begin
      map_upper = c - 31'd1;
    end else begin
      map_upper = c;
    end
  endfunction

  function automatic cp_t map_lower(cp_t c);
    if (in_range(c, 31'h41, 31'h5A) || in_range(c, 31'hC0, 31'hDE) ||
        in_range(c, GreekLowerLo - CaseOffset, GreekLowerHi - CaseOffset) ||
        in_range(c, CyrLowerLo - CaseOffset, CyrLowerHi - CaseOffset)) begin
      map_lower = c + CaseOffset;
    end else if (in_range(c, CyrLowerExtLo - CyrExtOffset, CyrLowerExtHi - CyrExtOffset)) begin
      map_lower = c + CyrExtOffset;
    end else if (even_pair_range(c)) begin
      map_lower = c + 31'd1;
    end else begin
      map_lower = c;
    end
  endfunction

  function automatic logic is_lower(cp_t c);
    is_lower = in_range(c, 31'h61, 31'h7A) ||
               ((c != 31'hF7) && in_range(c, 31'hE0, 31'hFE)) ||
               in_range(c, GreekLowerLo, GreekLowerHi) ||
               in_range(c, CyrLowerLo, CyrLowerExtHi) ||
               odd_pair_range(c);
  endfunction

  function automatic logic is_upper(cp_t c);
    is_upper = in_range(c, 31'h41, 31'h5A) ||
               ((c != 31'hD7) && in_range(c, 31'hC0, 31'hDE)) ||
               in_range(c, GreekLowerLo - CaseOffset, GreekLowerHi - CaseOffset) ||
               in_range(c, CyrLowerExtLo - CyrExtOffset, CyrLowerHi - CaseOffset) ||
               even_pair_range(c);
  endfunction

  function automatic logic is_space(cp_t c);
    is_space = in_range(c, 31'h09, 31'h0D) || (c == 31'h20) || (c == 31'hA0) ||
               (c == OghamSpace) || (c == MongolVowelSep) || (c == NarrowNbsp) ||
               (c == 31'h205F) || (c == 31'h3000) || (c == ZeroWidthNbsp) ||
               in_range(c, 31'h2000, 31'h200B);
  endfunction

endpackage

// ===== hw/rtl/utf8dc_decode.sv =====
// Byte-level sequence decoder: gathers continuation bytes into a code point.
`timescale 1ns / 1ps

module utf8dc_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic [7:0]             byte_in,
  output logic                   byte_stall,
  output logic                   item_valid,
  output utf8dc_pkg::dec_item_t  item,
  input  logic                   item_ready
);

  utf8dc_pkg::cnt_t      pending_count, pending_count_next;
  utf8dc_pkg::cp_t       partial_point, partial_point_next;
  utf8dc_pkg::cnt_t      total_bytes, total_bytes_next;
  logic                  item_valid_next;
  utf8dc_pkg::dec_item_t item_calc;
  logic                  emit;
  logic                  accept;
  utf8dc_pkg::cnt_t      lead_k;
  utf8dc_pkg::cp_t       shifted;
  utf8dc_pkg::cnt_t      tot_inc;
  utf8dc_pkg::cnt_t      pend_dec;

  assign byte_stall = item_valid && !item_ready;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    pending_count_next = pending_count;
    partial_point_next = partial_point;
    total_bytes_next   = total_bytes;
    emit               = 1'b0;
    item_calc          = '0;
    lead_k             = utf8dc_pkg::lead_len(byte_in);
    shifted            = {partial_point[24:0], byte_in[5:0]};
    tot_inc            = total_bytes + 3'd1;
    pend_dec           = pending_count - 3'd1;
    if (accept) begin
      if (pending_count != 3'd0) begin
        pending_count_next = pend_dec;
        if (pend_dec == 3'd0) begin
          emit                 = 1'b1;
          item_calc.code_point = shifted;
          item_calc.seq_bytes  = tot_inc;
          partial_point_next   = '0;
          total_bytes_next     = '0;
        end else begin
          partial_point_next = shifted;
          total_bytes_next   = tot_inc;
        end
      end else if (byte_in < utf8dc_pkg::LeadMultiLo) begin
        emit                 = 1'b1;
        item_calc.code_point = {24'd0, byte_in[6:0]};
        item_calc.seq_bytes  = 3'd1;
      end else if (byte_in >= utf8dc_pkg::LeadBadLo) begin
        emit                 = 1'b1;
        item_calc.seq_bytes  = 3'd1;
        item_calc.bad_lead   = 1'b1;
      end else begin
        pending_count_next = lead_k;
        partial_point_next = {24'd0, byte_in[6:0] & (7'h7F >> lead_k)};
        total_bytes_next   = 3'd1;
      end
    end
  end

  always_comb begin
    if (accept && emit) begin
      item_valid_next = 1'b1;
    end else if (item_ready) begin
      item_valid_next = 1'b0;
    end else begin
      item_valid_next = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      partial_point <= '0;
      total_bytes   <= '0;
      item_valid    <= 1'b0;
    end else begin
      pending_count <= pending_count_next;
      partial_point <= partial_point_next;
      total_bytes   <= total_bytes_next;
      item_valid    <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      item <= item_calc;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= 3'd5)
    else $error("pending continuation count out of range");

  a_sequence_length: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 3'd0) |-> ((total_bytes != 3'd0) &&
                                 ({1'b0, total_bytes} + {1'b0, pending_count} <= 4'd6)))
    else $error("sequence length bookkeeping inconsistent");

  a_bad_lead_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.bad_lead) |-> ((item.code_point == '0) && (item.seq_bytes == 3'd1)))
    else $error("bad lead item carries a code point");

  a_item_bytes: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> ((item.seq_bytes != 3'd0) && (item.seq_bytes != 3'd7)))
    else $error("item byte count out of range");

endmodule

// ===== hw/rtl/utf8dc_classify.sv =====
// Result stage: case mapping and character class flags of a decoded code point.
`timescale 1ns / 1ps

module utf8dc_classify (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  utf8dc_pkg::dec_item_t  item,
  output logic                   item_ready,
  output logic                   result_valid,
  input  logic                   result_stall,
  output utf8dc_pkg::cp_t        code_point,
  output utf8dc_pkg::cnt_t       seq_bytes,
  output utf8dc_pkg::cp_t        upper_form,
  output utf8dc_pkg::cp_t        lower_form,
  output logic                   lower_flag,
  output logic                   upper_flag,
  output logic                   space_flag,
  output logic                   bad_lead
);

  logic result_valid_next;
  logic load;

  assign item_ready = !result_valid || !result_stall;
  assign load       = item_valid && item_ready;

  always_comb begin
    if (item_ready) begin
      result_valid_next = item_valid;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= item.code_point;
      seq_bytes  <= item.seq_bytes;
      upper_form <= utf8dc_pkg::map_upper(item.code_point);
      lower_form <= utf8dc_pkg::map_lower(item.code_point);
      lower_flag <= utf8dc_pkg::is_lower(item.code_point);
      upper_flag <= utf8dc_pkg::is_upper(item.code_point);
      space_flag <= utf8dc_pkg::is_space(item.code_point);
      bad_lead   <= item.bad_lead;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(lower_flag && upper_flag))
    else $error("code point flagged both lower and upper case");

  a_bad_lead_plain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_lead) |->
      ((upper_form == '0) && (lower_form == '0) && !lower_flag && !upper_flag && !space_flag))
    else $error("bad lead result carries mappings or flags");

endmodule

// ===== hw/rtl/utf8_decode_classify_core.sv =====
// Top level of the streaming UTF-8 decoder with case mapping and classification.
//
//   channel   direction  handshake                  payload
//   byte      in         byte_valid / byte_stall    byte_in
//   result    out        result_valid / result_stall code_point, seq_bytes, upper_form,
//                                                   lower_form, lower_flag, upper_flag,
//                                                   space_flag, bad_lead
//
// One byte is taken every cycle while result_stall is low.
// A result is held in the decode register, then in the result register, after its final byte.
// Bytes that leave a sequence open produce no result.
// Reset clears the partial code point, counts and both valid flags.
// byte_stall rises only when both stage registers hold items and result_stall is high.
`timescale 1ns / 1ps

module utf8_decode_classify_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  logic [7:0]              byte_in,
  output logic                    result_valid,
  input  logic                    result_stall,
  output utf8dc_pkg::cp_t         code_point,
  output utf8dc_pkg::cnt_t        seq_bytes,
  output utf8dc_pkg::cp_t         upper_form,
  output utf8dc_pkg::cp_t         lower_form,
  output logic                    lower_flag,
  output logic                    upper_flag,
  output logic                    space_flag,
  output logic                    bad_lead
);

  logic                  item_valid;
  logic                  item_ready;
  utf8dc_pkg::dec_item_t item;

  utf8dc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_in    (byte_in),
    .byte_stall (byte_stall),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  utf8dc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .seq_bytes    (seq_bytes),
    .upper_form   (upper_form),
    .lower_form   (lower_form),
    .lower_flag   (lower_flag),
    .upper_flag   (upper_flag),
    .space_flag   (space_flag),
    .bad_lead     (bad_lead)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming UTF-8 decoder with case mapping and classification.
`timescale 1ns / 1ps

module testbench;

  typedef utf8dc_pkg::cp_t  cp_t;
  typedef utf8dc_pkg::cnt_t cnt_t;

  typedef struct packed {
    cp_t  code_point;
    cnt_t seq_bytes;
    cp_t  upper_form;
    cp_t  lower_form;
    logic lower_flag;
    logic upper_flag;
    logic space_flag;
    logic bad_lead;
  } utf8_result_t;

  typedef struct {
    logic [7:0]   value;
    bit           fixed;
    utf8_result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] byte_in = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  cp_t        code_point;
  cnt_t       seq_bytes;
  cp_t        upper_form;
  cp_t        lower_form;
  logic       lower_flag;
  logic       upper_flag;
  logic       space_flag;
  logic       bad_lead;

  cnt_t pend_cnt = '0;
  cp_t  acc_point = '0;
  cnt_t seq_len = '0;

  utf8_result_t expected_results [$];
  stim_row_t    stim_rows [$];
  int           errors = 0;

  int unsigned boundary_points [$] = '{
    'h08, 'h0E, 'h1F, 'h21, 'h40, 'h41, 'h5A, 'h5B, 'h60, 'h61, 'h7A, 'h7B,
    'h9F, 'hA1, 'hBF, 'hC0, 'hD7, 'hDE, 'hDF, 'hE0, 'hF7, 'hFE, 'hFF, 'h100,
    'h17D, 'h17E, 'h17F, 'h390, 'h391, 'h3A9, 'h3AA, 'h3B0, 'h3B1, 'h3C9, 'h3CA,
    'h3FF, 'h400, 'h40F, 'h410, 'h42F, 'h430, 'h44F, 'h450, 'h45F, 'h460, 'h461,
    'h480, 'h481, 'h482, 'h489, 'h48A, 'h48B, 'h52E, 'h52F, 'h530, 'h167F, 'h1681,
    'h180D, 'h180F, 'h1FFF, 'h200C, 'h202E, 'h2030, 'h205E, 'h2060, 'h2FFF, 'h3001,
    'hFEFE, 'hFF00
  };

  int unsigned space_points [$] = '{
    'h09, 'h0A, 'h0B, 'h0C, 'h0D, 'h20, 'hA0, 'h1680, 'h180E, 'h202F, 'h205F,
    'h3000, 'hFEFF, 'h2000, 'h2005, 'h200B
  };

  utf8_decode_classify_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_in      (byte_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .seq_bytes    (seq_bytes),
    .upper_form   (upper_form),
    .lower_form   (lower_form),
    .lower_flag   (lower_flag),
    .upper_flag   (upper_flag),
    .space_flag   (space_flag),
    .bad_lead     (bad_lead)
  );

  always #5 clk = ~clk;

  function automatic bit in_span(cp_t v, cp_t lo, cp_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic bit odd_pair(cp_t c);
    return c[0] && (in_span(c, 31'h101, 31'h17E) || in_span(c, 31'h461, 31'h481) ||
                    in_span(c, 31'h48B, 31'h52F));
  endfunction

  function automatic bit even_pair(cp_t c);
    return !c[0] && (in_span(c, 31'h100, 31'h17D) || in_span(c, 31'h460, 31'h480) ||
                     in_span(c, 31'h48A, 31'h52E));
  endfunction

  function automatic cp_t upcase(cp_t c);
    if (in_span(c, 31'h61, 31'h7A) || in_span(c, 31'hE0, 31'hFE) ||
        in_span(c, 31'h3B1, 31'h3C9) || in_span(c, 31'h430, 31'h44F)) return c - 31'h20;
    if (in_span(c, 31'h450, 31'h45F)) return c - 31'h50;
    if (odd_pair(c)) return c - 31'd1;
    return c;
  endfunction

  function automatic cp_t downcase(cp_t c);
    if (in_span(c, 31'h41, 31'h5A) || in_span(c, 31'hC0, 31'hDE) ||
        in_span(c, 31'h391, 31'h3A9) || in_span(c, 31'h410, 31'h42F)) return c + 31'h20;
    if (in_span(c, 31'h400, 31'h40F)) return c + 31'h50;
    if (even_pair(c)) return c + 31'd1;
    return c;
  endfunction

  function automatic bit is_small_letter(cp_t c);
    return in_span(c, 31'h61, 31'h7A) || (c != 31'hF7 && in_span(c, 31'hE0, 31'hFE)) ||
           in_span(c, 31'h3B1, 31'h3C9) || in_span(c, 31'h430, 31'h45F) || odd_pair(c);
  endfunction

  function automatic bit is_capital_letter(cp_t c);
    return in_span(c, 31'h41, 31'h5A) || (c != 31'hD7 && in_span(c, 31'hC0, 31'hDE)) ||
           in_span(c, 31'h391, 31'h3A9) || in_span(c, 31'h400, 31'h42F) || even_pair(c);
  endfunction

  function automatic bit is_white_space(cp_t c);
    return in_span(c, 31'h09, 31'h0D) || c == 31'h20 || c == 31'hA0 || c == 31'h1680 ||
           c == 31'h180E || c == 31'h202F || c == 31'h205F || c == 31'h3000 ||
           c == 31'hFEFF || in_span(c, 31'h2000, 31'h200B);
  endfunction

  function automatic utf8_result_t classify_point(cp_t c, cnt_t n, logic bad);
    utf8_result_t r;
    r.code_point = c;
    r.seq_bytes  = n;
    r.upper_form = upcase(c);
    r.lower_form = downcase(c);
    r.lower_flag = is_small_letter(c);
    r.upper_flag = is_capital_letter(c);
    r.space_flag = is_white_space(c);
    r.bad_lead   = bad;
    return r;
  endfunction

  // advance the decoder state by one byte; return 1 where a code point completes or a bad lead is seen
  function automatic bit decode_byte(logic [7:0] b, output utf8_result_t r);
    cnt_t k;
    cp_t  done;
    r = '0;
    if (pend_cnt != 0) begin
      acc_point = (acc_point << 6) | cp_t'(b[5:0]);
      seq_len   = seq_len + 3'd1;
      pend_cnt  = pend_cnt - 3'd1;
      if (pend_cnt != 0) return 1'b0;
      done      = acc_point;
      r         = classify_point(done, seq_len, 1'b0);
      acc_point = '0;
      seq_len   = '0;
      return 1'b1;
    end
    if (b < 8'hC0) begin
      r = classify_point(cp_t'(b[6:0]), 3'd1, 1'b0);
      return 1'b1;
    end
    if (b >= 8'hFE) begin
      r = classify_point('0, 3'd1, 1'b1);
      return 1'b1;
    end
    if (b < 8'hE0) k = 3'd1;
    else if (b < 8'hF0) k = 3'd2;
    else if (b < 8'hF8) k = 3'd3;
    else if (b < 8'hFC) k = 3'd4;
    else k = 3'd5;
    acc_point = cp_t'(b & (8'h7F >> k));
    pend_cnt  = k;
    seq_len   = 3'd1;
    return 1'b0;
  endfunction

  function automatic utf8_result_t fixed_point(cp_t c, cp_t up, cp_t lo, logic lf,
                                               logic uf, logic sf, logic bad);
    utf8_result_t r;
    r = '{c, 3'd1, up, lo, lf, uf, sf, bad};
    return r;
  endfunction

  task automatic add_row(logic [7:0] v);
    stim_row_t row;
    row.value = v;
    row.fixed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_fixed(logic [7:0] v, utf8_result_t want);
    stim_row_t row;
    row.value = v;
    row.fixed = 1'b1;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  function automatic cp_t pick_point();
    case ($urandom_range(0, 7))
      0: return cp_t'($urandom_range(0, 'h7F));
      1: return cp_t'($urandom_range('h80, 'h17F));
      2: return cp_t'($urandom_range('h380, 'h3CF));
      3: return cp_t'($urandom_range('h3F0, 'h53F));
      4: return cp_t'(space_points[$urandom_range(0, space_points.size() - 1)]);
      5: return cp_t'(boundary_points[$urandom_range(0, boundary_points.size() - 1)]);
      6: return cp_t'($urandom_range(0, 'hFFFF));
      default: return cp_t'($urandom() >> $urandom_range(1, 31));
    endcase
  endfunction

  // mostly well-formed sequences, some overlong or untagged, the rest raw bytes
  task automatic add_random_item();
    cp_t        cp;
    cp_t        part;
    int         n;
    int         minlen;
    bit         untagged;
    logic [7:0] b;
    if ($urandom_range(0, 6) == 0) begin
      add_row(8'($urandom_range(0, 255)));
      return;
    end
    cp = pick_point();
    if (cp < 31'h80) minlen = 1;
    else if (cp < 31'h800) minlen = 2;
    else if (cp < 31'h10000) minlen = 3;
    else if (cp < 31'h200000) minlen = 4;
    else if (cp < 31'h4000000) minlen = 5;
    else minlen = 6;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(minlen, 6) : minlen;
    untagged = ($urandom_range(0, 7) == 0);
    if (n == 1) begin
      add_row({1'b0, cp[6:0]});
    end else begin
      part = (cp >> (6 * (n - 1))) & cp_t'(8'h7F >> n);
      add_row((8'hFF << (8 - n)) | part[7:0]);
      for (int i = n - 2; i >= 0; i--) begin
        part = (cp >> (6 * i)) & 31'h3F;
        b = {2'b10, part[5:0]};
        if (untagged) b[7:6] = 2'($urandom_range(0, 3));
        add_row(b);
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [30:0] got, logic [30:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    utf8_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result code_point 0x%0h", code_point));
      end else begin
        want = expected_results.pop_front();
        check_field("code_point", code_point, want.code_point);
        check_field("seq_bytes", 31'(seq_bytes), 31'(want.seq_bytes));
        check_field("upper_form", upper_form, want.upper_form);
        check_field("lower_form", lower_form, want.lower_form);
        check_field("lower_flag", 31'(lower_flag), 31'(want.lower_flag));
        check_field("upper_flag", 31'(upper_flag), 31'(want.upper_flag));
        check_field("space_flag", 31'(space_flag), 31'(want.space_flag));
        check_field("bad_lead", 31'(bad_lead), 31'(want.bad_lead));
      end
    end
  end

  initial begin : drain_results
    int hold;
    int taken;
    bit calm;
    hold  = 0;
    taken = 0;
    calm  = 0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 5);
      // hold off long enough to back up the pipe
      if (taken == 150 || taken == 500) hold = 120;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  initial begin : feed_bytes
    utf8_result_t got;
    stim_row_t    row;
    int           gap;
    bit           burst;
    burst = 0;

    add_fixed(8'h00, fixed_point(31'h00, 31'h00, 31'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_fixed(8'h7F, fixed_point(31'h7F, 31'h7F, 31'h7F, 1'b0, 1'b0, 1'b0, 1'b0));
    add_fixed(8'h41, fixed_point(31'h41, 31'h41, 31'h61, 1'b0, 1'b1, 1'b0, 1'b0));
    add_fixed(8'h7A, fixed_point(31'h7A, 31'h5A, 31'h7A, 1'b1, 1'b0, 1'b0, 1'b0));
    add_fixed(8'h20, fixed_point(31'h20, 31'h20, 31'h20, 1'b0, 1'b0, 1'b1, 1'b0));
    add_fixed(8'h80, fixed_point(31'h00, 31'h00, 31'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_fixed(8'hBF, fixed_point(31'h3F, 31'h3F, 31'h3F, 1'b0, 1'b0, 1'b0, 1'b0));
    add_fixed(8'hFE, fixed_point(31'h00, 31'h00, 31'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    add_fixed(8'hFF, fixed_point(31'h00, 31'h00, 31'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(8'hC3); add_row(8'h97);
    add_row(8'hCE); add_row(8'hB1);
    add_row(8'hE1); add_row(8'h9A); add_row(8'h80);
    add_row(8'hFD);
    repeat (5) add_row(8'hBF);
    add_row(8'hC3); add_row(8'h41);
    while (stim_rows.size() < 770) add_random_item();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[idx]) begin
      row = stim_rows[idx];
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_valid <= 1'b1;
      byte_in    <= row.value;
      do @(posedge clk); while (byte_stall);
      if (decode_byte(row.value, got))
        expected_results.push_back(row.fixed ? row.want : got);
    end
    byte_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) report_mismatch("results still outstanding");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/utf8dc_pkg.sv
hw/rtl/utf8dc_decode.sv
hw/rtl/utf8dc_classify.sv
hw/rtl/utf8_decode_classify_core.sv
dv/testbench.sv
